### rtl/core/i128dm_pkg.sv
// ----------------------------------------------------------------------------
// i128dm_pkg
// Shared widths, kind field layout, sequencer states and the result bundle
// of the 128-bit divide/modulo core.
// ----------------------------------------------------------------------------
package i128dm_pkg;

  localparam int HALF_W   = 64;
  localparam int WORD_W   = 2 * HALF_W;
  localparam int KIND_W   = 2;
  localparam int STEP_CNT = WORD_W;
  localparam int CNT_W    = $clog2(STEP_CNT);

  // Kind field: low bit picks remainder over quotient, high bit picks signed
  localparam int KIND_REM_BIT    = 0;
  localparam int KIND_SIGNED_BIT = 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_NEG_A = 5'b00010,
    ST_NEG_B = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_FIX   = 5'b10000
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              dbz;
  } res_t;

endpackage

### rtl/core/int128_divide_modulo_core.sv
// ----------------------------------------------------------------------------
// int128_divide_modulo_core
// 128-bit signed/unsigned divide and modulo by restoring division, one
// quotient bit per cycle, with a registered result stage.
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid, in_ready, kind, dividend_lo/hi,        | to core
//           | divisor_lo/hi                                    |
//   out     | out_valid, out_ready, result_lo/hi,              | from core
//           | divide_by_zero                                   |
//
// A transfer with a nonzero divisor passes two negation steps, 128 restoring
// steps and a sign fix-up step before out_valid, all through one shared
// 128-bit subtractor. A zero divisor goes straight to the fix-up step.
// in_ready rises together with out_valid, as the result moves to the output
// register, so a new item is taken while a finished result still waits there.
// A stalled output holds the next result in the fix-up step until the output
// register frees up. rst is synchronous and clears the sequencer and out_valid.
// ----------------------------------------------------------------------------
module int128_divide_modulo_core
  import i128dm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] kind,
  input  logic [HALF_W-1:0] dividend_lo,
  input  logic [HALF_W-1:0] dividend_hi,
  input  logic [HALF_W-1:0] divisor_lo,
  input  logic [HALF_W-1:0] divisor_hi,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HALF_W-1:0] result_lo,
  output logic [HALF_W-1:0] result_hi,
  output logic              divide_by_zero
);

  logic done;
  logic take;
  res_t res;

  i128dm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .dividend ({dividend_hi, dividend_lo}),
    .divisor  ({divisor_hi, divisor_lo}),
    .done     (done),
    .take     (take),
    .res      (res)
  );

  // Load the output register when it is empty or draining this cycle
  assign take = done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_lo      <= res.value[HALF_W-1:0];
      result_hi      <= res.value[WORD_W-1:HALF_W];
      divide_by_zero <= res.dbz;
    end
  end

endmodule

### rtl/core/i128dm_alu.sv
// ----------------------------------------------------------------------------
// i128dm_alu
// Shared 128-bit subtractor with borrow out. Serves operand negation,
// every trial subtract of the restoring loop and the final sign fix-up.
// ----------------------------------------------------------------------------
module i128dm_alu
  import i128dm_pkg::*;
(
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [WORD_W-1:0] diff,
  output logic              borrow
);

  // Subtract one word extended by a zero bit, keep the borrow
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

### rtl/core/i128dm_ctrl.sv
// ----------------------------------------------------------------------------
// i128dm_ctrl
// Sequencer and working registers of the divider. Takes magnitudes, runs
// one restoring step per cycle through the shared subtractor, then applies
// the sign of the result and hands it to the output stage.
// ----------------------------------------------------------------------------
module i128dm_ctrl
  import i128dm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] kind,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  input  logic              take,
  output res_t              res
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] dvd;     // dividend, then quotient shifting in
  logic [WORD_W-1:0] dvs;
  logic [WORD_W-1:0] rem;
  logic              is_signed;
  logic              want_rem;
  logic              neg_a;
  logic              neg_b;
  logic              dbz;

  logic [WORD_W-1:0] alu_a, alu_b, alu_diff;
  logic              alu_borrow;
  logic [WORD_W-1:0] rem_sh;
  logic [WORD_W-1:0] sel;
  logic              neg_res;
  logic              accept;
  logic              dvs_zero;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign dvs_zero = (divisor == '0);
  assign rem_sh   = {rem[WORD_W-2:0], dvd[WORD_W-1]};
  assign sel      = want_rem ? rem : dvd;
  assign neg_res  = is_signed && (want_rem ? neg_a : (neg_a ^ neg_b));
  assign done     = (state == ST_FIX);

  i128dm_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

  // Route operands of the shared subtractor
  always_comb begin
    alu_a = '0;
    alu_b = sel;
    case (state)
      ST_NEG_A: alu_b = dvd;
      ST_NEG_B: alu_b = dvs;
      ST_DIV: begin
        alu_a = rem_sh;
        alu_b = dvs;
      end
      default: alu_b = sel;
    endcase
  end

  // Result: zero on a zero divisor, else the selected word with its sign
  always_comb begin
    res.dbz   = dbz;
    res.value = dbz ? '0 : (neg_res ? alu_diff : sel);
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = dvs_zero ? ST_FIX : ST_NEG_A;
      ST_NEG_A: state_next = ST_NEG_B;
      ST_NEG_B: state_next = ST_DIV;
      ST_DIV:   if (cnt == CNT_W'(STEP_CNT - 1)) state_next = ST_FIX;
      ST_FIX:   if (take) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) cnt <= cnt + 1'b1;
      else                 cnt <= '0;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          dvd       <= dividend;
          dvs       <= divisor;
          rem       <= '0;
          is_signed <= kind[KIND_SIGNED_BIT];
          want_rem  <= kind[KIND_REM_BIT];
          neg_a     <= kind[KIND_SIGNED_BIT] && dividend[WORD_W-1];
          neg_b     <= kind[KIND_SIGNED_BIT] && divisor[WORD_W-1];
          dbz       <= dvs_zero;
        end
      end
      ST_NEG_A: if (neg_a) dvd <= alu_diff;
      ST_NEG_B: if (neg_b) dvs <= alu_diff;
      ST_DIV: begin
        // Keep the difference when the divisor fits, shift the quotient bit in
        rem <= alu_borrow ? rem_sh : alu_diff;
        dvd <= {dvd[WORD_W-2:0], ~alu_borrow};
      end
      default: ;
    endcase
  end

  // Zero divisor goes straight to the fix-up step with the flag set
  a_zero_path: assert property (@(posedge clk) disable iff (rst)
    accept && dvs_zero |=> (state == ST_FIX) && dbz)
    else $error("zero divisor did not take the short path");

  // Loop ends after exactly the last step
  a_loop_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) && (cnt == CNT_W'(STEP_CNT - 1)) |=> (state == ST_FIX))
    else $error("divide loop did not end on the last step");

  // A waiting result holds until the output stage takes it
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    done && !take |=> done && $stable(res))
    else $error("pending result changed before transfer");

  // Counter runs only inside the loop
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DIV) |-> (cnt == '0))
    else $error("step counter moved outside the loop");

endmodule

### sim/tb_int128_divide_modulo_core.sv
// ----------------------------------------------------------------------------
// tb_int128_divide_modulo_core
// Self-checking bench for the 128-bit divide/modulo core. Each accepted
// operation is predicted with native 128-bit arithmetic on the operand
// magnitudes, with the sign fix-ups applied afterwards. The predictions are
// queued and compared field by field against every result transfer. A
// directed set of corner cases is followed by random operands of mixed
// magnitude. The sender uses bursts with random gaps and the receiver stalls
// on a random pattern.
// ----------------------------------------------------------------------------
module tb_int128_divide_modulo_core
  import i128dm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_OPS   = 1450;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 160;

  localparam logic [KIND_W-1:0] KIND_UQUO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UREM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SQUO = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SREM = 2'd3;

  localparam logic [WORD_W-1:0] MOST_NEG  = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] MOST_POS  = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] ALL_ONES  = {WORD_W{1'b1}};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_op_t;

  logic              clk            = 1'b0;
  logic              rst            = 1'b1;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [KIND_W-1:0] kind           = '0;
  logic [HALF_W-1:0] dividend_lo    = '0;
  logic [HALF_W-1:0] dividend_hi    = '0;
  logic [HALF_W-1:0] divisor_lo     = '0;
  logic [HALF_W-1:0] divisor_hi     = '0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic [HALF_W-1:0] result_lo;
  logic [HALF_W-1:0] result_hi;
  logic              divide_by_zero;

  div_op_t op_queue[$];
  res_t    quot_rem_due[$];
  div_op_t op_on_bus;

  int burst_left;
  int gap_left;
  int gap_sel;
  int ready_left;
  int stall_left;
  int stall_sel;
  int idle_cycles;
  int n_ops_sent;
  int n_results;
  int n_zero_div;
  int n_signed;
  int n_errors;

  int128_divide_modulo_core u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .dividend_lo    (dividend_lo),
    .dividend_hi    (dividend_hi),
    .divisor_lo     (divisor_lo),
    .divisor_hi     (divisor_hi),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_lo      (result_lo),
    .result_hi      (result_hi),
    .divide_by_zero (divide_by_zero)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Quotient or remainder of one operation, signs fixed up after an
  // unsigned divide of the magnitudes
  function automatic res_t predict_quot_rem(div_op_t op);
    logic              signed_op;
    logic              neg_num;
    logic              neg_den;
    logic [WORD_W-1:0] mag_num;
    logic [WORD_W-1:0] mag_den;
    logic [WORD_W-1:0] quo;
    logic [WORD_W-1:0] rem;
    res_t              res;
    signed_op = op.kind[KIND_SIGNED_BIT];
    res.dbz   = (op.divisor == '0);
    res.value = '0;
    if (!res.dbz) begin
      neg_num = signed_op & op.dividend[WORD_W-1];
      neg_den = signed_op & op.divisor[WORD_W-1];
      mag_num = neg_num ? (~op.dividend + 1'b1) : op.dividend;
      mag_den = neg_den ? (~op.divisor + 1'b1) : op.divisor;
      quo     = mag_num / mag_den;
      rem     = mag_num % mag_den;
      if (op.kind[KIND_REM_BIT]) begin
        res.value = neg_num ? (~rem + 1'b1) : rem;
      end else begin
        res.value = (neg_num ^ neg_den) ? (~quo + 1'b1) : quo;
      end
    end
    return res;
  endfunction

  // Random operand of mixed magnitude: full width, short, short negative,
  // single set bit, close to an edge value, or with its low bits cleared
  function automatic logic [WORD_W-1:0] rand_operand();
    logic [WORD_W-1:0] raw;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] edge_val;
    int                nbits;
    raw   = {$urandom(), $urandom(), $urandom(), $urandom()};
    nbits = $urandom_range(0, WORD_W);
    mask  = ALL_ONES >> (WORD_W - nbits);
    case ($urandom_range(0, 3))
      0:       edge_val = MOST_NEG;
      1:       edge_val = MOST_POS;
      2:       edge_val = ALL_ONES;
      default: edge_val = '0;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: return raw;
      3, 4, 5: return raw & mask;
      6:       return ~(raw & mask) + 1'b1;
      7:       return {{(WORD_W-1){1'b0}}, 1'b1} << $urandom_range(0, WORD_W - 1);
      8:       return edge_val + raw[1:0];
      default: return raw & ~mask;
    endcase
  endfunction

  function automatic void add_op(logic [KIND_W-1:0] k, logic [WORD_W-1:0] a,
                                 logic [WORD_W-1:0] b);
    div_op_t op;
    op.kind     = k;
    op.dividend = a;
    op.divisor  = b;
    op_queue.push_back(op);
  endfunction

  // Stimulus: directed corner cases, then random operations; drain and report
  initial begin
    div_op_t op;
    // zero divisor on every kind
    add_op(KIND_UQUO, ALL_ONES, '0);
    add_op(KIND_UREM, MOST_NEG, '0);
    add_op(KIND_SQUO, -128'd5, '0);
    add_op(KIND_SREM, 128'd12345, '0);
    // most negative value over minus one, over one and over itself
    add_op(KIND_SQUO, MOST_NEG, ALL_ONES);
    add_op(KIND_SREM, MOST_NEG, ALL_ONES);
    add_op(KIND_UQUO, MOST_NEG, ALL_ONES);
    add_op(KIND_SQUO, MOST_NEG, 128'd1);
    add_op(KIND_SREM, MOST_NEG, MOST_NEG);
    // sign combinations
    add_op(KIND_SQUO, -128'd7, 128'd2);
    add_op(KIND_SREM, -128'd7, 128'd2);
    add_op(KIND_SQUO, 128'd7, -128'd2);
    add_op(KIND_SREM, 128'd7, -128'd2);
    add_op(KIND_SQUO, -128'd7, -128'd2);
    add_op(KIND_SREM, -128'd7, -128'd2);
    add_op(KIND_SQUO, MOST_POS, MOST_NEG);
    // unsigned extremes
    add_op(KIND_UQUO, ALL_ONES, 128'd1);
    add_op(KIND_UREM, ALL_ONES, ALL_ONES - 1'b1);
    add_op(KIND_UQUO, '0, ALL_ONES);
    add_op(KIND_UREM, 128'd3, ALL_ONES);
    add_op(KIND_UQUO, ALL_ONES, MOST_NEG);
    add_op(KIND_UREM, {64'h0123_4567_89ab_cdef, 64'h0}, {64'h1, 64'h0});
    for (int i = 0; i < RANDOM_OPS; i++) begin
      op.kind     = KIND_W'($urandom_range(0, 3));
      op.dividend = rand_operand();
      op.divisor  = ($urandom_range(0, 39) == 0) ? '0 : rand_operand();
      op_queue.push_back(op);
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    while (op_queue.size() != 0 || in_valid || quot_rem_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d operations (%0d signed, %0d zero divisor), checked %0d results",
             n_ops_sent, n_signed, n_zero_div, n_results);
    $display("Sender bursts and receiver stalls were randomized; %0d mismatches",
             n_errors);
    if (n_errors == 0 && quot_rem_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Driver: bursts of operations with random gaps, hold each until transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && in_ready) begin
        quot_rem_due.push_back(predict_quot_rem(op_on_bus));
        n_ops_sent++;
        if (op_on_bus.divisor == '0) n_zero_div++;
        if (op_on_bus.kind[KIND_SIGNED_BIT]) n_signed++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (op_queue.size() != 0) begin
          op_on_bus = op_queue.pop_front();
          kind        <= op_on_bus.kind;
          dividend_lo <= op_on_bus.dividend[HALF_W-1:0];
          dividend_hi <= op_on_bus.dividend[WORD_W-1:HALF_W];
          divisor_lo  <= op_on_bus.divisor[HALF_W-1:0];
          divisor_hi  <= op_on_bus.divisor[WORD_W-1:HALF_W];
          in_valid    <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // end of burst: pick the next burst length and the gap before it
            burst_left = $urandom_range(0, 15);
            gap_sel    = $urandom_range(0, 9);
            if (gap_sel < 5) gap_left = 0;
            else if (gap_sel < 8) gap_left = $urandom_range(1, 8);
            else gap_left = $urandom_range(9, 200);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: runs of ready cycles broken by short or long stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      ready_left = 0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (ready_left > 0) begin
      ready_left--;
      out_ready <= 1'b1;
    end else begin
      ready_left = $urandom_range(0, 40);
      stall_sel  = $urandom_range(0, 7);
      if (stall_sel < 3) stall_left = 0;
      else if (stall_sel < 6) stall_left = $urandom_range(1, 6);
      else stall_left = $urandom_range(7, 200);
      out_ready <= 1'b1;
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (quot_rem_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual lo=%h hi=%h dbz=%b",
                 $time, result_lo, result_hi, divide_by_zero);
        n_errors++;
      end else begin
        res_t exp_res;
        exp_res = quot_rem_due.pop_front();
        n_results++;
        if (result_lo !== exp_res.value[HALF_W-1:0]) begin
          $display("%0t: result_lo mismatch, expected %h actual %h",
                   $time, exp_res.value[HALF_W-1:0], result_lo);
          n_errors++;
        end
        if (result_hi !== exp_res.value[WORD_W-1:HALF_W]) begin
          $display("%0t: result_hi mismatch, expected %h actual %h",
                   $time, exp_res.value[WORD_W-1:HALF_W], result_hi);
          n_errors++;
        end
        if (divide_by_zero !== exp_res.dbz) begin
          $display("%0t: divide_by_zero mismatch, expected %b actual %b",
                   $time, exp_res.dbz, divide_by_zero);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

### int128_divide_modulo_core.f
rtl/core/i128dm_pkg.sv
rtl/core/i128dm_alu.sv
rtl/core/i128dm_ctrl.sv
rtl/core/int128_divide_modulo_core.sv
sim/tb_int128_divide_modulo_core.sv
